// ----- sv/sorted_unique_values_core_macros.svh -----
// assertion macros for the sorted unique values core
// expects clk and arst_n in the scope of each use
`ifndef SORTED_UNIQUE_VALUES_CORE_MACROS_SVH
`define SORTED_UNIQUE_VALUES_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define SUV_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("suv same-cycle check failed");

// next-cycle implication, off during reset
`define SUV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("suv next-cycle check failed");

`endif

// ----- sv/suv_pkg.sv -----
// shared types and constants for the sorted unique values core
// no dependencies
`timescale 1ns / 1ps

package suv_pkg;

	localparam int VAL_W = 16;

	typedef struct packed {
		logic [VAL_W-1:0] sample_value;
		logic             final_item;
	} sample_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] unique_value;
		logic             last_result;
		logic             overflow;
	} result_req_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctl_t;

endpackage

// ----- sv/sorted_unique_values_core.sv -----
// sorted unique values core: row of compare-and-shift cells, top level
// depends on suv_pkg, suv_cell and sorted_unique_values_core_macros.svh
// throughput: one sample per cycle while collecting; after the final sample the
//   row drains one result per cycle while result_stall does not block it, with sample_stall held high
// the first result is loaded into the output register on the first drain step after the final sample
// reset clears the cell valid bits, the count and the overflow flag; no clearing pass
`timescale 1ns / 1ps

module sorted_unique_values_core
	import suv_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_req_t sample,
	output logic        result_valid,
	input  logic        result_stall,
	output result_req_t result
);

	`include "sorted_unique_values_core_macros.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// per-cell signals, one entry per cell, each read at its own place
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_eq;
	logic [CAPACITY-1:0] cell_valid;
	logic [VAL_W-1:0]    cell_value [CAPACITY];

	logic [CNT_W-1:0] count_q;
	logic             draining_q;
	logic             overflow_q;
	logic             result_valid_q;
	result_req_t      result_q;

	logic      sample_accept;
	logic      dup;
	logic      full;
	logic      drain_step;
	cell_ctl_t ctl;

	// collect phase takes requests; drain phase blocks them
	assign sample_stall  = draining_q;
	assign sample_accept = sample_valid && !draining_q;

	// a duplicate hits exactly one cell; the store is full when the last cell holds data
	assign dup  = |cell_eq;
	assign full = cell_valid[CAPACITY-1];

	// drain only when the output register is free or emptying this cycle
	assign drain_step = draining_q && (!result_valid_q || !result_stall);

	assign ctl.insert = sample_accept && !dup && !full;
	assign ctl.drain  = drain_step;

	// the row: each cell sees its left and right neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             p_lt;
		logic             p_valid;
		logic [VAL_W-1:0] p_value;
		logic             n_valid;
		logic [VAL_W-1:0] n_value;

		if (i == 0) begin : g_head
			// head cell takes the new value whenever it is not smaller
			assign p_lt    = 1'b1;
			assign p_valid = 1'b1;
			assign p_value = sample.sample_value;
		end else begin : g_body
			assign p_lt    = cell_lt[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			// tail cell empties on drain
			assign n_valid = 1'b0;
			assign n_value = '0;
		end else begin : g_mid
			assign n_valid = cell_valid[i+1];
			assign n_value = cell_value[i+1];
		end

		suv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_value  (sample.sample_value),
			.prev_lt    (p_lt),
			.prev_valid (p_valid),
			.prev_value (p_value),
			.next_valid (n_valid),
			.next_value (n_value),
			.lt         (cell_lt[i]),
			.eq         (cell_eq[i]),
			.valid      (cell_valid[i]),
			.value      (cell_value[i])
		);
	end

	// count, phase and overflow tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (drain_step) begin
			count_q <= count_q - CNT_W'(1);
			if (count_q == CNT_W'(1)) begin
				// last result leaves, set is done
				draining_q <= 1'b0;
				overflow_q <= 1'b0;
			end
		end else if (sample_accept) begin
			if (ctl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (!dup && full) begin
				overflow_q <= 1'b1;
			end
			if (sample.final_item) begin
				draining_q <= 1'b1;
			end
		end
	end

	// output register between the row and the result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (drain_step) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_step) begin
			result_q.unique_value <= cell_value[0];
			result_q.last_result  <= (count_q == CNT_W'(1));
			result_q.overflow     <= overflow_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// the number of set valid bits equals the count
	`SUV_ASSERT_IMPLY(a_count_matches_cells, 1'b1, $countones(cell_valid) == count_q)
	// a drain never runs on an empty row
	`SUV_ASSERT_IMPLY(a_drain_not_empty, draining_q, count_q != '0)
	// the last drain step ends the drain phase with an empty row and a clear overflow flag
	`SUV_ASSERT_NEXT(a_drain_ends, drain_step && (count_q == CNT_W'(1)),
		!draining_q && (count_q == '0) && !overflow_q)

endmodule

// ----- sv/suv_cell.sv -----
// one compare-and-shift cell of the sorted store
// depends on suv_pkg
`timescale 1ns / 1ps

module suv_cell
	import suv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [VAL_W-1:0] new_value,
	input  logic             prev_lt,
	input  logic             prev_valid,
	input  logic [VAL_W-1:0] prev_value,
	input  logic             next_valid,
	input  logic [VAL_W-1:0] next_value,
	output logic             lt,
	output logic             eq,
	output logic             valid,
	output logic [VAL_W-1:0] value
);

	logic             valid_q;
	logic [VAL_W-1:0] value_q;

	assign lt    = valid_q && (value_q < new_value);
	assign eq    = valid_q && (value_q == new_value);
	assign valid = valid_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.drain) begin
			valid_q <= next_valid;
		end else if (ctl.insert && !lt) begin
			valid_q <= prev_lt ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			value_q <= next_value;
		end else if (ctl.insert && !lt) begin
			// new value lands where the left neighbor is still smaller
			value_q <= prev_lt ? new_value : prev_value;
		end
	end

endmodule

// ----- test/tb_top.sv -----
// testbench for sorted_unique_values_core: streams sets of 16-bit values and checks
// the sorted distinct results, last marks and overflow flags against a local set model
// depends on suv_pkg and sorted_unique_values_core
`timescale 1ns / 1ps

module tb_top;
	import suv_pkg::*;

	localparam int CAPACITY = 64;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	sample_req_t sample;
	logic        result_valid;
	logic        result_stall;
	result_req_t result;

	// local copy of the block state: sorted distinct values and the dropped flag
	logic [VAL_W-1:0] held_values[$];
	bit               held_overflow = 1'b0;
	// results owed by the block, oldest first
	result_req_t      pending_uniques[$];

	int error_count = 0;
	bit gaps_on = 1'b1;   // random idling on both sides
	int pause_left = 0;   // short receiver pause after each result
	int hold_left = 0;    // long receiver hold-off, counted by the receiver

	sorted_unique_values_core #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// insert one accepted request into the sorted set; a final request
	// turns the whole set into owed results and empties it
	function automatic void sort_into_held_set(input sample_req_t req);
		int          pos;
		int          n;
		bit          dup;
		result_req_t res;
		pos = 0;
		while (pos < held_values.size() && held_values[pos] < req.sample_value)
			pos++;
		dup = (pos < held_values.size()) && (held_values[pos] == req.sample_value);
		if (!dup) begin
			// a new value with no room left is dropped and flagged
			if (held_values.size() >= CAPACITY)
				held_overflow = 1'b1;
			else
				held_values.insert(pos, req.sample_value);
		end
		if (req.final_item) begin
			n = held_values.size();
			for (int k = 0; k < n; k++) begin
				res.unique_value = held_values[k];
				res.last_result  = (k == n - 1);
				res.overflow     = held_overflow;
				pending_uniques.push_back(res);
			end
			held_values.delete();
			held_overflow = 1'b0;
		end
	endfunction

	// offer one request after a random gap and wait for the handshake;
	// valid stays high into the next request when that one has no gap
	task automatic send_sample(input logic [VAL_W-1:0] value, input logic is_final);
		sample_req_t req;
		int          gap;
		req.sample_value = value;
		req.final_item   = is_final;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= req;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sort_into_held_set(req);
	endtask

	// random set of the given size; narrow values collide often
	task automatic send_random_set(input int size, input bit narrow);
		logic [VAL_W-1:0] value;
		for (int i = 0; i < size; i++) begin
			if (narrow)
				value = VAL_W'($urandom_range(0, 15));
			else
				value = VAL_W'($urandom);
			send_sample(value, i == size - 1);
		end
	endtask

	// set of many distinct values spread by an odd stride, with a few repeats;
	// the final request is either a repeat or one more distinct value
	task automatic send_spread_set(input int distinct, input bit end_on_repeat);
		logic [VAL_W-1:0] base;
		logic [VAL_W-1:0] stride;
		logic [VAL_W-1:0] value;
		base   = VAL_W'($urandom);
		stride = VAL_W'($urandom | 1);
		for (int k = 0; k < distinct; k++) begin
			value = VAL_W'(base + k * stride);
			send_sample(value, 1'b0);
			// occasional repeat of the value just sent
			if (k % 8 == 3)
				send_sample(value, 1'b0);
		end
		if (end_on_repeat)
			send_sample(base, 1'b1);
		else
			send_sample(VAL_W'(base + distinct * stride), 1'b1);
	endtask

	// a set of one value: a single result that is also the last
	task automatic test_lone_value();
		send_sample(16'h1234, 1'b1);
	endtask

	// both ends of the value range and alternating bit patterns,
	// closed by a final request that repeats a held value
	task automatic test_field_extremes();
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hFFFE, 1'b0);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h0000, 1'b1);
		// top value arriving as the final request
		send_sample(16'h0064, 1'b0);
		send_sample(16'hFFFF, 1'b1);
	endtask

	// repeats are ignored, including on the final request
	task automatic test_duplicates();
		send_sample(16'd7, 1'b0);
		send_sample(16'd7, 1'b0);
		send_sample(16'd3, 1'b0);
		send_sample(16'd7, 1'b0);
		send_sample(16'd3, 1'b0);
		send_sample(16'd7, 1'b1);
	endtask

	// exactly a full store, no overflow
	task automatic test_full_store();
		send_spread_set(CAPACITY, 1'b1);
	endtask

	// more distinct values than the store holds: extras dropped, every result flagged
	task automatic test_overflow();
		send_spread_set(CAPACITY + 5, 1'b0);
	endtask

	// receiver holds off while two sets go in back to back, so the row
	// collects the first set, drains into a blocked output and stalls the input side
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_left = 150;
		send_random_set(10, 1'b0);
		send_random_set(12, 1'b1);
		gaps_on = 1'b1;
	endtask

	// mostly short random sets, some with idling and some without
	task automatic test_random_sets();
		int sent;
		int size;
		sent = 0;
		while (sent < 20) begin
			size = $urandom_range(1, 12);
			gaps_on = ($urandom_range(0, 3) != 0);
			send_random_set(size, 1'($urandom_range(0, 1)));
			sent += size;
		end
		gaps_on = 1'b1;
	endtask

	// receiver side: long hold-off first, then the short pause drawn per result
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (pause_left > 0) begin
				pause_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// compare every accepted result with the oldest owed one
	always @(posedge clk) begin
		result_req_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_uniques.size() == 0) begin
				$error("unexpected result: unique_value %0d last_result %0b overflow %0b",
					result.unique_value, result.last_result, result.overflow);
				error_count++;
			end else begin
				want = pending_uniques.pop_front();
				if (result.unique_value !== want.unique_value) begin
					$error("unique_value: expected %0d, got %0d",
						want.unique_value, result.unique_value);
					error_count++;
				end
				if (result.last_result !== want.last_result) begin
					$error("last_result: expected %0b, got %0b",
						want.last_result, result.last_result);
					error_count++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b",
						want.overflow, result.overflow);
					error_count++;
				end
			end
			pause_left = gaps_on ? $urandom_range(0, 4) : 0;
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_lone_value();
		test_field_extremes();
		test_duplicates();
		test_full_store();
		test_overflow();
		test_backpressure();
		test_random_sets();

		@(negedge clk);
		sample_valid <= 1'b0;
		// drain whatever is still owed, then watch for stray output
		while (pending_uniques.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("sorted_unique_values_core: match");
		else
			$display("sorted_unique_values_core: mismatch");
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#200us;
		$display("sorted_unique_values_core: mismatch");
		$finish;
	end

endmodule
